>>> rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and codes for the page frame allocator
// Request commands, result status codes and the register map.
// ----------------------------------------------------------------------------
package pfa_pkg;

    // field widths fixed by the item format
    localparam int CMD_W    = 1;
    localparam int PROC_W   = 3;
    localparam int PAGE_W   = 4;
    localparam int STATUS_W = 2;
    localparam int FRAME_W  = 4;
    localparam int NFR_W    = 5;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    // request commands
    localparam cmd_t CMD_ALLOC = 1'b0;
    localparam cmd_t CMD_FREE  = 1'b1;

    // result status codes
    localparam status_t ST_ALLOCATED = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_FREED     = 2'd2;
    localparam status_t ST_UNMAPPED  = 2'd3;

    // register map: word index taken from paddr[2]
    localparam logic REG_NUM_FRAMES = 1'b0;
    localparam logic [NFR_W-1:0] NUM_FRAMES_RESET = 5'd16;

endpackage

>>> rtl/page_frame_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_allocator: first-fit physical frame allocator
// Keeps a busy bit per frame and a page map per process in a memory.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries one request item: tuser is the command (allocate or free),
//   tdata holds the process id and page number. m_axis returns one result
//   item per request: tuser is the status, tdata the frame index.
//   Allocate takes the lowest free frame below num_frames and maps the page
//   to it; free releases the frame the page is mapped to.
//   num_frames is written through the APB port at byte address 0.
// Timing
//   Each item first has its page-map memory read, then its lookup and the
//   write-back. One item is in work at a time, so the next item is taken
//   only once the last one has left the lookup.
//   A result sits in the output register until taken; the next item is
//   accepted meanwhile and waits in its write-back cycle while m_axis stalls.
// Reset
//   All frames become free. The page map is then cleared by a sweep over all
//   PROCESS_COUNT * PAGES_PER_PROCESS entries, one entry a cycle, during
//   which s_axis_tready stays low; APB writes are taken throughout.
// ----------------------------------------------------------------------------
module page_frame_allocator #(
    parameter int MAX_FRAME_COUNT   = 16,
    parameter int PROCESS_COUNT     = 8,
    parameter int PAGES_PER_PROCESS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [2:0] process_id, [6:3] page_number
    input  logic [0:0]  s_axis_tuser,   // [0] command
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [3:0] frame_index
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pfa_pkg::*;

    localparam int MAP_DEPTH = PROCESS_COUNT * PAGES_PER_PROCESS;
    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int FW        = $clog2(MAX_FRAME_COUNT);
    localparam int MAP_W     = FW + 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } state_t;

    state_t                    state_reg;
    logic [MAP_AW-1:0]         clr_cnt_reg;
    logic [MAX_FRAME_COUNT-1:0] busy_reg, busy_next;
    logic [NFR_W-1:0]          num_frames_reg;

    // request held while in work
    cmd_t                      cmd_reg;
    logic                      inrange_reg;
    logic [MAP_AW-1:0]         slot_reg;

    // page-map memory: {valid, frame}
    logic [MAP_W-1:0]          map_mem [MAP_DEPTH];
    logic [MAP_W-1:0]          rd_data_reg;
    logic                      wr_en;
    logic [MAP_AW-1:0]         wr_addr;
    logic [MAP_W-1:0]          wr_data;

    // output register
    logic                      out_valid_reg;
    status_t                   out_status_reg, out_status_next;
    logic [FRAME_W-1:0]        out_frame_reg, out_frame_next;

    // request decode
    logic [PROC_W-1:0]         in_proc;
    logic [PAGE_W-1:0]         in_page;
    logic                      in_range;
    logic [31:0]               slot_full;
    logic                      accept;
    logic                      look_fire;

    // first-fit search
    logic                      free_found;
    logic [FW-1:0]             free_idx;
    logic                      map_valid;
    logic [FW-1:0]             map_frame;
    logic [FW-1:0]             res_frame;
    logic [FW+FRAME_W-1:0]     res_frame_ext;
    logic                      apb_wr;

    assign in_proc   = s_axis_tdata[PROC_W-1:0];
    assign in_page   = s_axis_tdata[PROC_W+PAGE_W-1:PROC_W];
    assign in_range  = (int'(in_proc) < PROCESS_COUNT) && (int'(in_page) < PAGES_PER_PROCESS);
    assign slot_full = 32'(in_proc) * 32'(PAGES_PER_PROCESS) + 32'(in_page);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign look_fire     = (state_reg == S_LOOK) && (!out_valid_reg || m_axis_tready);

    assign map_valid = rd_data_reg[FW];
    assign map_frame = rd_data_reg[FW-1:0];

    // lowest free frame below the configured count
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_FRAME_COUNT - 1; i >= 0; i--) begin
            if (!busy_reg[i] && (i < int'(num_frames_reg))) begin
                free_found = 1'b1;
                free_idx   = FW'(i);
            end
        end
    end

    // result, write-back and busy update of the item in work, and the clear-sweep write
    always_comb begin
        busy_next       = busy_reg;
        out_status_next = ST_FULL;
        res_frame       = '0;
        wr_en           = 1'b0;
        wr_addr         = slot_reg;
        wr_data         = '0;
        if (state_reg == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
        end else if (!inrange_reg) begin
            out_status_next = (cmd_reg == CMD_ALLOC) ? ST_FULL : ST_UNMAPPED;
        end else if (cmd_reg == CMD_ALLOC) begin
            if (free_found) begin
                out_status_next     = ST_ALLOCATED;
                res_frame           = free_idx;
                wr_en               = look_fire;
                wr_data             = {1'b1, free_idx};
                busy_next[free_idx] = 1'b1;
            end else begin
                out_status_next = ST_FULL;
            end
        end else begin
            if (map_valid) begin
                out_status_next = ST_FREED;
                res_frame       = map_frame;
                wr_en           = look_fire;
                if (int'(map_frame) < MAX_FRAME_COUNT) begin
                    busy_next[map_frame] = 1'b0;
                end
            end else begin
                out_status_next = ST_UNMAPPED;
            end
        end
        res_frame_ext  = {{FRAME_W{1'b0}}, res_frame};
        out_frame_next = res_frame_ext[FRAME_W-1:0];
    end

    // page-map memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            map_mem[wr_addr] <= wr_data;
        end
        if (accept) begin
            rd_data_reg <= map_mem[slot_full[MAP_AW-1:0]];
        end
    end

    // control state machine and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            busy_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            // result taken with no new one behind it
            if (m_axis_tready && !look_fire) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == MAP_AW'(MAP_DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        cmd_reg     <= s_axis_tuser;
                        inrange_reg <= in_range;
                        slot_reg    <= slot_full[MAP_AW-1:0];
                        state_reg   <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (look_fire) begin
                        busy_reg       <= busy_next;
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= out_status_next;
                        out_frame_reg  <= out_frame_next;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // configuration register
    assign apb_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_frames_reg <= NUM_FRAMES_RESET;
        end else if (apb_wr && (paddr[2] == REG_NUM_FRAMES)) begin
            num_frames_reg <= pwdata[NFR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NUM_FRAMES) ? {{(32-NFR_W){1'b0}}, num_frames_reg} : '0;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {{(8-FRAME_W){1'b0}}, out_frame_reg};

endmodule

>>> rtl/pfa_checker.sv
// ----------------------------------------------------------------------------
// pfa_checker: port-level checks for the page frame allocator
// Watches the stream and reset behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module pfa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import pfa_pkg::*;

    // a stalled result item stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    // error results carry frame zero
    a_err_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == ST_FULL || m_axis_tuser == ST_UNMAPPED)
        |-> m_axis_tdata == 8'd0)
        else $error("error result with nonzero frame");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result item valid after reset");

    // an item accepted with the output empty is answered once its memory read and lookup are done
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
        else $error("result item late");

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/page_frame_allocator_test.sv
// ----------------------------------------------------------------------------
// page_frame_allocator_test: self-checking bench for the page frame allocator
// A directed table walks empty and full memory, reallocation, frame counts of
// zero, one, full and saturated, then random allocate/free traffic runs with
// changing frame counts. Every result is checked against a prediction or the table.
// ----------------------------------------------------------------------------
module page_frame_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pfa_pkg::*;

    localparam int FRAME_SLOTS       = 16;
    localparam int PROCS             = 8;
    localparam int PAGES             = 16;
    localparam int MAP_DEPTH         = PROCS * PAGES;
    localparam int SEGMENTS          = 29;
    localparam int SEGMENT_ITEMS     = 56;
    localparam int REALLOC_BUDGET    = 6;
    localparam int LONG_STALL_CYCLES = 300;
    localparam int QUIET_LIMIT       = 3000;
    localparam int TAIL_CYCLES       = 10;

    typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_t;

    typedef struct packed {
        status_t            status;
        logic [FRAME_W-1:0] frame;
    } frame_result_t;

    typedef struct {
        row_kind_t          kind;
        cmd_t               cmd;
        logic [PROC_W-1:0]  proc;
        logic [PAGE_W-1:0]  page;
        bit                 typed;
        status_t            status;
        logic [FRAME_W-1:0] frame;
        logic [NFR_W-1:0]   frames_cfg;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [2:0] process_id, [6:3] page_number
    logic [0:0]  s_axis_tuser;   // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [3:0] frame_index
    logic [1:0]  m_axis_tuser;   // [1:0] status
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    page_frame_allocator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // allocator state as seen from outside
    bit                 frame_busy  [FRAME_SLOTS];
    logic [PROC_W-1:0]  frame_owner [FRAME_SLOTS];
    bit                 page_mapped [MAP_DEPTH];
    logic [FRAME_W-1:0] page_frame  [MAP_DEPTH];
    logic [NFR_W-1:0]   frame_count_cfg;

    frame_result_t pending_frame_results[$];
    stim_row_t     directed_rows[$];

    // expectation typed into the table for the item on offer
    bit                 offer_typed;
    status_t            offer_status;
    logic [FRAME_W-1:0] offer_frame;

    int fail_count;
    int quiet_cycles;
    int requests_taken;
    int results_checked;
    int config_writes;
    int status_seen[4];
    int traffic_mode;
    bit stall_request;
    bit stall_served;

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // first-fit allocate or free, updating the local state
    task automatic predict_frame_result(input cmd_t cmd, input logic [PROC_W-1:0] proc,
                                        input logic [PAGE_W-1:0] page,
                                        output frame_result_t res);
        int limit;
        int slot;
        bit found;
        limit = (frame_count_cfg > FRAME_SLOTS) ? FRAME_SLOTS : int'(frame_count_cfg);
        res.status = (cmd == CMD_ALLOC) ? ST_FULL : ST_UNMAPPED;
        res.frame  = '0;
        found      = 1'b0;
        if (proc < PROCS && page < PAGES) begin
            slot = int'(proc) * PAGES + int'(page);
            if (cmd == CMD_ALLOC) begin
                // lowest free frame among the configured count
                for (int f = 0; f < limit; f++) begin
                    if (!found && !frame_busy[f]) begin
                        found            = 1'b1;
                        frame_busy[f]    = 1'b1;
                        frame_owner[f]   = proc;
                        page_mapped[slot] = 1'b1;
                        page_frame[slot] = FRAME_W'(f);
                        res.status       = ST_ALLOCATED;
                        res.frame        = FRAME_W'(f);
                    end
                end
            end else if (page_mapped[slot]) begin
                res.status = ST_FREED;
                res.frame  = page_frame[slot];
                frame_busy[page_frame[slot]]  = 1'b0;
                frame_owner[page_frame[slot]] = '0;
                page_mapped[slot] = 1'b0;
                page_frame[slot]  = '0;
            end
        end
    endtask

    // scoreboard: result check, request prediction, activity count
    always @(posedge aclk) begin : scoreboard
        frame_result_t want;
        frame_result_t predicted;
        bit            active;
        active = 1'b0;
        if (m_axis_tvalid && m_axis_tready) begin
            active = 1'b1;
            results_checked++;
            if (pending_frame_results.size() == 0) begin
                $error("unexpected result item: status %0d frame_index %0d",
                       m_axis_tuser, m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_frame_results.pop_front();
                status_seen[want.status]++;
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata !== {4'b0, want.frame}) begin
                    $error("frame_index: expected %0d, got %0d", want.frame, m_axis_tdata);
                    fail_count++;
                end
            end
        end
        if (s_axis_tvalid && s_axis_tready) begin
            active = 1'b1;
            requests_taken++;
            predict_frame_result(cmd_t'(s_axis_tuser[0]), s_axis_tdata[2:0],
                                 s_axis_tdata[6:3], predicted);
            if (offer_typed) begin
                predicted.status = offer_status;
                predicted.frame  = offer_frame;
            end
            pending_frame_results.push_back(predicted);
        end
        if (psel && penable && pready)
            active = 1'b1;
        quiet_cycles = active ? 0 : quiet_cycles + 1;
    end

    // watchdog on cycles with no accepted item, taken result or APB transfer
    initial begin
        @(negedge aclk);
        while (quiet_cycles < QUIET_LIMIT)
            @(negedge aclk);
        $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random backpressure plus one long hold-off
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_request && !stall_served) begin
                stall_served = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(negedge aclk);
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >=
                                  (traffic_mode == 0 ? 68 : traffic_mode == 1 ? 38 : 0));
            end
        end
    end

    // offer one request item and hold it until accepted
    task automatic offer_request(input cmd_t cmd, input logic [PROC_W-1:0] proc,
                                 input logic [PAGE_W-1:0] page, input bit typed,
                                 input status_t st, input logic [FRAME_W-1:0] fr);
        int pct;
        pct = (traffic_mode == 0) ? 38 : (traffic_mode == 1) ? 68 : 0;
        if ($urandom_range(0, 99) < pct) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(0, 99) < pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, page, proc};
        s_axis_tuser  <= cmd;
        offer_typed  = typed;
        offer_status = st;
        offer_frame  = fr;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_frame_results.size() != 0)
            @(negedge aclk);
    endtask

    // write num_frames over apb and read it back
    task automatic write_num_frames(input logic [NFR_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_NUM_FRAMES, 2'b00};
        pwdata  <= 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        frame_count_cfg = value;
        config_writes++;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata[NFR_W-1:0] !== value) begin
            $error("num_frames: expected %0d, got %0d", value, prdata[NFR_W-1:0]);
            fail_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic stim_row_t req_row(input cmd_t cmd, input int proc, input int page);
        stim_row_t r;
        r = '{ROW_REQUEST, cmd, PROC_W'(proc), PAGE_W'(page), 1'b0, ST_ALLOCATED, '0, '0};
        return r;
    endfunction

    function automatic stim_row_t fixed_row(input cmd_t cmd, input int proc, input int page,
                                            input status_t st, input int fr);
        stim_row_t r;
        r = '{ROW_REQUEST, cmd, PROC_W'(proc), PAGE_W'(page), 1'b1, st, FRAME_W'(fr), '0};
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input int value);
        stim_row_t r;
        r = '{ROW_CONFIG, CMD_ALLOC, '0, '0, 1'b0, ST_ALLOCATED, '0, NFR_W'(value)};
        return r;
    endfunction

    // stimulus
    initial begin : stimulus
        cmd_t               cmd;
        logic [PROC_W-1:0]  proc;
        logic [PAGE_W-1:0]  page;
        int                 limit;
        int                 free_frames;
        int                 slot;
        int                 reallocs;
        int                 pick;
        int                 mapped_slots[$];
        stim_row_t          row;
        logic [NFR_W-1:0]   nf;

        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        offer_typed   = 1'b0;
        offer_status  = ST_ALLOCATED;
        offer_frame   = '0;
        fail_count      = 0;
        quiet_cycles    = 0;
        requests_taken  = 0;
        results_checked = 0;
        config_writes   = 0;
        status_seen     = '{0, 0, 0, 0};
        traffic_mode    = 0;
        stall_request   = 1'b0;
        stall_served    = 1'b0;
        reallocs        = 0;
        frame_count_cfg = NUM_FRAMES_RESET;
        foreach (frame_busy[f]) begin
            frame_busy[f]  = 1'b0;
            frame_owner[f] = '0;
        end
        foreach (page_mapped[s]) begin
            page_mapped[s] = 1'b0;
            page_frame[s]  = '0;
        end

        // directed table: empty map, reallocation, zero, saturated, single and full frame counts
        directed_rows.push_back(fixed_row(CMD_FREE,  0, 0,  ST_UNMAPPED, 0));
        directed_rows.push_back(fixed_row(CMD_ALLOC, 0, 0,  ST_ALLOCATED, 0));
        directed_rows.push_back(fixed_row(CMD_ALLOC, 7, 15, ST_ALLOCATED, 1));
        directed_rows.push_back(req_row(CMD_ALLOC, 7, 15));   // remap, old frame stays held
        directed_rows.push_back(req_row(CMD_FREE,  7, 15));
        directed_rows.push_back(fixed_row(CMD_FREE,  7, 15, ST_UNMAPPED, 0));
        directed_rows.push_back(cfg_row(0));
        directed_rows.push_back(fixed_row(CMD_ALLOC, 3, 5,  ST_FULL, 0));
        directed_rows.push_back(req_row(CMD_FREE,  0, 0));    // frame outside the count
        directed_rows.push_back(cfg_row(31));
        directed_rows.push_back(req_row(CMD_ALLOC, 5, 10));
        directed_rows.push_back(req_row(CMD_ALLOC, 2, 9));
        directed_rows.push_back(cfg_row(1));
        directed_rows.push_back(req_row(CMD_ALLOC, 1, 1));
        directed_rows.push_back(req_row(CMD_FREE,  5, 10));
        directed_rows.push_back(req_row(CMD_ALLOC, 1, 1));
        directed_rows.push_back(cfg_row(16));
        directed_rows.push_back(req_row(CMD_ALLOC, 4, 6));
        directed_rows.push_back(req_row(CMD_ALLOC, 6, 3));
        directed_rows.push_back(req_row(CMD_FREE,  2, 9));
        directed_rows.push_back(req_row(CMD_ALLOC, 3, 12));

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CONFIG) begin
                drain_results();
                write_num_frames(row.frames_cfg);
            end else begin
                offer_request(row.cmd, row.proc, row.page, row.typed, row.status, row.frame);
            end
        end

        // random traffic in segments, each with its own frame count
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain_results();
            traffic_mode <= seg * 3 / SEGMENTS;
            pick = $urandom_range(0, 19);
            if (pick == 0)
                nf = 0;
            else if (pick == 1)
                nf = 1;
            else if (pick == 2)
                nf = NFR_W'($urandom_range(17, 31));
            else
                nf = NFR_W'($urandom_range(2, 16));
            write_num_frames(nf);
            for (int i = 0; i < SEGMENT_ITEMS; i++) begin
                if (traffic_mode == 2 && !stall_request && i == 20)
                    stall_request <= 1'b1;
                limit = (frame_count_cfg > FRAME_SLOTS) ? FRAME_SLOTS : int'(frame_count_cfg);
                free_frames = 0;
                for (int f = 0; f < limit; f++)
                    if (!frame_busy[f])
                        free_frames++;
                mapped_slots.delete();
                foreach (page_mapped[s])
                    if (page_mapped[s])
                        mapped_slots.push_back(s);
                if ($urandom_range(0, 99) < 12) begin
                    // noise: any fields, remapping kept within a leak budget
                    cmd  = cmd_t'($urandom_range(0, 1));
                    proc = PROC_W'($urandom_range(0, PROCS - 1));
                    page = PAGE_W'($urandom_range(0, PAGES - 1));
                    if (cmd == CMD_ALLOC && page_mapped[int'(proc) * PAGES + int'(page)] &&
                        free_frames > 0) begin
                        if (reallocs < REALLOC_BUDGET)
                            reallocs++;
                        else
                            cmd = CMD_FREE;
                    end
                end else begin
                    // well formed: allocate an unmapped page or free a mapped one
                    if (mapped_slots.size() == 0)
                        cmd = CMD_ALLOC;
                    else if (free_frames > 0)
                        cmd = ($urandom_range(0, 99) < 60) ? CMD_ALLOC : CMD_FREE;
                    else
                        cmd = ($urandom_range(0, 99) < 15) ? CMD_ALLOC : CMD_FREE;
                    if (cmd == CMD_ALLOC) begin
                        do slot = $urandom_range(0, MAP_DEPTH - 1); while (page_mapped[slot]);
                    end else begin
                        slot = mapped_slots[$urandom_range(0, mapped_slots.size() - 1)];
                    end
                    proc = PROC_W'(slot / PAGES);
                    page = PAGE_W'(slot % PAGES);
                end
                offer_request(cmd, proc, page, 1'b0, ST_ALLOCATED, '0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("%0d requests, %0d results checked, %0d frame-count writes",
                 requests_taken, results_checked, config_writes);
        $display("allocated %0d, full %0d, freed %0d, not mapped %0d",
                 status_seen[ST_ALLOCATED], status_seen[ST_FULL],
                 status_seen[ST_FREED], status_seen[ST_UNMAPPED]);
        if (fail_count == 0 && pending_frame_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> page_frame_allocator.f
rtl/pfa_pkg.sv
rtl/page_frame_allocator.sv
rtl/pfa_checker.sv
tb/page_frame_allocator_test.sv
